// ===== hw/rtl/cicmd_pkg.sv =====
// Package: shared constants, types and opcodes for the CIC mass deposit unit.
`timescale 1ns / 1ps
package cicmd_pkg;
  localparam int unsigned GridSideDefault = 32;
  localparam logic [31:0] CpuReset = 32'd65536;
  localparam logic [16:0] OneQ16 = 17'd65536;

  localparam logic [1:0] FUNC_DEPOSIT = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] mass;
    logic [14:0] cell_index;
  } item_t;

  typedef struct packed {
    logic        wr;
    logic [63:0] add;
    logic        clr;
  } upd_t;
endpackage

// ===== hw/rtl/cicmd_grid_mem.sv =====
// Density grid memory: one write and one registered read port, with reset sweep.
`timescale 1ns / 1ps
module cicmd_grid_mem #(
  parameter int unsigned AW = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  output logic          busy_o
);
  logic [63:0] mem [2**AW];
  logic [AW:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!clr_q[AW]) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!clr_q[AW]) begin
      mem[clr_q[AW-1:0]] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  assign busy_o = !clr_q[AW];
endmodule

// ===== hw/rtl/cicmd_weight_gen.sv =====
// Deposit front end: per-axis split, trilinear weights and scaled shares.
`timescale 1ns / 1ps
module cicmd_weight_gen #(
  parameter int unsigned GridSide = 32,
  parameter int unsigned IW = 5
) (
  input  logic            clk_i,
  input  logic [2:0]      step_i,
  input  logic [31:0]     pos_i,
  input  logic [31:0]     cpu_i,
  input  logic [31:0]     mass_i,
  input  logic [2:0]      corner_i,
  output logic [IW-1:0]   idx_o,
  output logic [63:0]     share_o
);
  import cicmd_pkg::*;
  // step 0..2: axis x/y/z product captured; 4..6: corner index out; used by controller sequence
  logic [63:0] s;
  logic [IW-1:0] lo_q [3];
  logic [IW-1:0] hi_q [3];
  logic [16:0] f_q [3];
  logic [16:0] wa, wb, wc;
  logic [33:0] p1;
  logic [16:0] w1_q;
  logic [33:0] p2;
  logic [16:0] w_q;
  logic [2:0] c_q;

  assign s = 64'(pos_i) * 64'(cpu_i);

  always_ff @(posedge clk_i) begin
    if (step_i < 3'd3) begin
      if (s[63:32] >= 32'(GridSide)) begin
        lo_q[step_i[1:0]] <= IW'(GridSide - 1);
        f_q[step_i[1:0]] <= OneQ16;
      end else begin
        lo_q[step_i[1:0]] <= s[32+IW-1:32];
        f_q[step_i[1:0]] <= {1'b0, s[31:16]};
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      hi_q[a] = (32'(lo_q[a]) + 32'd1 >= 32'(GridSide)) ? '0 : lo_q[a] + 1'b1;
    end
    wa = corner_i[2] ? f_q[0] : OneQ16 - f_q[0];
    wb = corner_i[1] ? f_q[1] : OneQ16 - f_q[1];
    wc = c_q[0] ? f_q[2] : OneQ16 - f_q[2];
    p1 = 34'(wa) * 34'(wb);
    p2 = 34'(w1_q) * 34'(wc);
  end

  always_ff @(posedge clk_i) begin
    w1_q <= p1[32:16];
    c_q <= corner_i;
    w_q <= p2[32:16];
    share_o <= 64'(mass_i) * 64'(w_q);
  end

  always_comb begin
    unique case (step_i)
      3'd4: idx_o = corner_i[2] ? hi_q[0] : lo_q[0];
      3'd5: idx_o = corner_i[1] ? hi_q[1] : lo_q[1];
      3'd6: idx_o = corner_i[0] ? hi_q[2] : lo_q[2];
      default: idx_o = '0;
    endcase
  end
endmodule

// ===== hw/rtl/cic_mass_deposit_grid_unit.sv =====
// Top level: cloud-in-cell mass deposition onto a periodic cubic density grid.
// Input channel s_axis: one beat per command. tuser carries func; tdata carries
// pos_x, pos_y, pos_z, mass, cell_index. Output m_axis: one beat per read,
// tdata = cell_density. cfg_we_i/cfg_wdata_i write cells_per_unit; write it
// only while no command is in flight.
// A deposit runs a sequencer: three axis products, then the eight corners one
// at a time, each with three index steps, one pipeline step, share, memory read
// and saturating write back through the grid memory with one read and one
// write port. s_axis_tready stays low after a deposit beat until the last
// corner has been written back and the sequencer is idle again.
// A read holds the input through ST_READ (memory read) and ST_RDW (output
// register load). A clear holds it through ST_READ; an unused func is dropped.
// After reset a clearing pass over every memory entry (32768 at default)
// zeroes the memory; no commands are accepted during it.
// A read result holds in the output register while m_axis_tready is low;
// further commands are accepted meanwhile, and a following read holds in its
// last step until the register frees.
`timescale 1ns / 1ps
module cic_mass_deposit_grid_unit #(
  parameter int unsigned GRID_SIDE = cicmd_pkg::GridSideDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // func
  input  logic [143:0] s_axis_tdata,   // pos_x, pos_y, pos_z, mass, cell_index, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata    // cell_density
);
  import cicmd_pkg::*;
  localparam int unsigned IW = $clog2(GRID_SIDE);
  localparam int unsigned Cells = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW = $clog2(Cells);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AXIS = 3'd1;
  localparam logic [2:0] ST_CORN = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_RDW  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [2:0] step_q, step_d;
  logic [2:0] corner_q, corner_d;
  logic [31:0] cpu_q;
  item_t it_q;
  logic [IW-1:0] ix_q, iy_q, iz_q, idx;
  logic [63:0] share;
  logic [AW-1:0] rd_addr, wr_addr, corner_addr;
  logic [63:0] rd_data, wr_data, sum;
  logic wr_en, busy, cy;
  logic [31:0] pos_sel;
  logic out_v_q;
  logic [63:0] out_q;
  logic out_load;
  upd_t upd;
  logic in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q <= CpuReset;
    end else if (cfg_we_i) begin
      cpu_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = (st_q == ST_IDLE) && !busy;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      it_q.func <= s_axis_tuser;
      it_q.pos_x <= s_axis_tdata[31:0];
      it_q.pos_y <= s_axis_tdata[63:32];
      it_q.pos_z <= s_axis_tdata[95:64];
      it_q.mass <= s_axis_tdata[127:96];
      it_q.cell_index <= s_axis_tdata[142:128];
    end
  end

  always_comb begin
    unique case (step_q)
      3'd0: pos_sel = it_q.pos_x;
      3'd1: pos_sel = it_q.pos_y;
      default: pos_sel = it_q.pos_z;
    endcase
  end

  cicmd_weight_gen #(.GridSide(GRID_SIDE), .IW(IW)) u_wgen (
    .clk_i, .step_i((st_q == ST_IDLE) ? 3'd7 : step_q), .pos_i(pos_sel), .cpu_i(cpu_q),
    .mass_i(it_q.mass), .corner_i(corner_q), .idx_o(idx), .share_o(share)
  );

  always_ff @(posedge clk_i) begin
    if (st_q == ST_CORN) begin
      unique case (step_q)
        3'd4: ix_q <= idx;
        3'd5: iy_q <= idx;
        3'd6: iz_q <= idx;
        default: ;
      endcase
    end
  end

  assign corner_addr = AW'((32'(ix_q) * GRID_SIDE + 32'(iy_q)) * GRID_SIDE + 32'(iz_q));
  assign in_range = 32'(it_q.cell_index) < 32'(Cells);
  assign rd_addr = (st_q == ST_CORN) ? corner_addr : AW'(it_q.cell_index);
  assign {cy, sum} = 65'(rd_data) + 65'(share);

  always_comb begin
    upd = '0;
    wr_addr = rd_addr;
    if (st_q == ST_CORN && step_q == 3'd2) begin
      upd.wr = 1'b1;
      upd.add = cy ? '1 : sum;
    end
    if (st_q == ST_READ && it_q.func == FUNC_CLEAR && in_range) begin
      upd.wr = 1'b1;
      upd.clr = 1'b1;
    end
    wr_en = upd.wr;
    wr_data = upd.clr ? '0 : upd.add;
  end

  cicmd_grid_mem #(.AW(AW)) u_mem (
    .clk_i, .rst_ni, .rd_addr_i(rd_addr), .rd_data_o(rd_data), .wr_en_i(wr_en),
    .wr_addr_i(wr_addr), .wr_data_i(wr_data), .busy_o(busy)
  );

  assign out_load = (st_q == ST_RDW) && (!out_v_q || m_axis_tready);

  // Corner steps: 4..6 index, 7 pipeline, 0 share, 1 read, 2 write
  always_comb begin
    st_d = st_q;
    step_d = step_q;
    corner_d = corner_q;
    unique case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          step_d = '0;
          corner_d = '0;
          priority case (s_axis_tuser)
            FUNC_DEPOSIT: st_d = ST_AXIS;
            FUNC_READ, FUNC_CLEAR: st_d = ST_READ;
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_AXIS: begin
        step_d = step_q + 1'b1;
        if (step_q == 3'd2) begin
          st_d = ST_CORN;
          step_d = 3'd4;
        end
      end
      ST_CORN: begin
        step_d = step_q + 1'b1;
        if (step_q == 3'd2) begin
          step_d = 3'd4;
          corner_d = corner_q + 1'b1;
          if (corner_q == 3'd7) st_d = ST_IDLE;
        end
      end
      ST_READ: st_d = (it_q.func == FUNC_READ) ? ST_RDW : ST_IDLE;
      ST_RDW: st_d = out_load ? ST_IDLE : ST_RDW;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      step_q <= '0;
      corner_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      step_q <= step_d;
      corner_q <= corner_d;
      if (out_load) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= in_range ? rd_data : '0;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;
endmodule

// ===== hw/rtl/cicmd_checker.sv =====
// Port checker for the CIC mass deposit unit, bound to the top level.
`timescale 1ns / 1ps
module cicmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  import cicmd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != FUNC_NOP |=> !s_axis_tready)
    else $error("accepted while busy");
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_READ |=> ##2 m_axis_tvalid)
    else $error("read result missing");
endmodule

bind cic_mass_deposit_grid_unit cicmd_checker u_chk (.*);
